// ===== src/gzbd_pkg.sv =====
// Shared constants for the zigzag Golomb bit decoder.
package gzbd_pkg;

  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned DIVISOR_W   = 16;
  localparam int unsigned VALUE_W     = 32;

  localparam logic [DIVISOR_W-1:0] DIVISOR_RESET = 16'd4;

  // clamp values for the signed result
  localparam logic [VALUE_W-1:0] VALUE_POS_MAX = 32'h7FFF_FFFF;
  localparam logic [VALUE_W-1:0] VALUE_NEG_MIN = 32'h8000_0000;

endpackage : gzbd_pkg

// ===== src/golomb_zigzag_bit_decoder.sv =====
// Top level of the zigzag-signed Golomb decoder that takes one coded bit per word.
//
// Input channel (s_axis_*): one coded bit per word in tdata[0], in stream order.
// Each code is a run of ones closed by a zero (the quotient q), then
// floor(log2(m)) remainder bits, MSB first, in plain binary.
// Output channel (m_axis_*): one word per finished code. tdata holds the signed
// value after zigzag unmapping of v = q*m + r (even v -> v/2, odd v ->
// -(v+1)/2), clamped to 32 bits; tuser[0] is set when the unary run overran
// the quotient counter and q was held at its maximum.
// Config channel (cfg_*): writes the Golomb divisor m; always ready. Only the
// low M_BITS bits count, and zero acts as one. Write it between codes.
// Throughput: one bit per cycle, back to back, while s_axis_tready is high.
// The parser holds one code and the value pipeline two, so a stalled receiver
// only backs up the input once all three result-side registers are full.
// Result path: the edge that takes the bit ending a code loads the parser
// output register, then the product register (one QUOTIENT_BITS x M_BITS
// multiply), then the add/unmap output register, which drives m_axis_tvalid.
// Reset: divisor returns to 4, any partial code is dropped, all valids clear.
module golomb_zigzag_bit_decoder #(
  parameter int unsigned QUOTIENT_BITS = 16,
  parameter int unsigned M_BITS        = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // config write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [gzbd_pkg::DIVISOR_W-1:0]  cfg_data_i,   // divisor_m
  // coded bit stream in
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [gzbd_pkg::IN_TDATA_W-1:0] s_axis_tdata, // [0] code_bit, [7:1] zero
  // decoded values out
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [gzbd_pkg::VALUE_W-1:0]    m_axis_tdata, // [31:0] decoded_value
  output logic                            m_axis_tuser  // [0] quotient_saturated
);

  import gzbd_pkg::*;

  logic [M_BITS-1:0]        div_q;

  logic                     code_valid;
  logic                     code_ready;
  logic [QUOTIENT_BITS-1:0] code_quot;
  logic [M_BITS-1:0]        code_div;
  logic [M_BITS-1:0]        code_rem;
  logic                     code_ovf;

  // divisor register; keep only the bits the datapath uses
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q <= DIVISOR_RESET[M_BITS-1:0];
    end else if (cfg_valid_i) begin
      div_q <= cfg_data_i[M_BITS-1:0];
    end
  end

  gzbd_bit_parser #(
    .QUOTIENT_BITS(QUOTIENT_BITS),
    .M_BITS       (M_BITS)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .bit_valid_i (s_axis_tvalid),
    .bit_ready_o (s_axis_tready),
    .code_bit_i  (s_axis_tdata[0]),
    .div_i       (div_q),
    .code_valid_o(code_valid),
    .code_ready_i(code_ready),
    .quot_o      (code_quot),
    .div_o       (code_div),
    .rem_o       (code_rem),
    .ovf_o       (code_ovf)
  );

  gzbd_value_unit #(
    .QUOTIENT_BITS(QUOTIENT_BITS),
    .M_BITS       (M_BITS)
  ) u_value (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .code_valid_i (code_valid),
    .code_ready_o (code_ready),
    .quot_i       (code_quot),
    .div_i        (code_div),
    .rem_i        (code_rem),
    .ovf_i        (code_ovf),
    .value_valid_o(m_axis_tvalid),
    .value_ready_i(m_axis_tready),
    .value_o      (m_axis_tdata),
    .sat_o        (m_axis_tuser)
  );

endmodule : golomb_zigzag_bit_decoder

// ===== src/gzbd_bit_parser.sv =====
// Bit parser: walks the unary run and remainder bits, registers each finished code.
module gzbd_bit_parser #(
  parameter int unsigned QUOTIENT_BITS = 16,
  parameter int unsigned M_BITS        = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     bit_valid_i,
  output logic                     bit_ready_o,
  input  logic                     code_bit_i,
  input  logic [M_BITS-1:0]        div_i,
  output logic                     code_valid_o,
  input  logic                     code_ready_i,
  output logic [QUOTIENT_BITS-1:0] quot_o,
  output logic [M_BITS-1:0]        div_o,
  output logic [M_BITS-1:0]        rem_o,
  output logic                     ovf_o
);

  localparam int unsigned CNT_W = (M_BITS > 1) ? $clog2(M_BITS) : 1;

  logic                     in_rem_q, in_rem_d;
  logic [QUOTIENT_BITS-1:0] q_cnt_q, q_cnt_d;
  logic                     ovf_q, ovf_d;
  logic [M_BITS-1:0]        rem_q, rem_d;
  logic [CNT_W-1:0]         left_q, left_d;
  logic                     code_v_q, code_v_d;

  logic [QUOTIENT_BITS-1:0] quot_q;
  logic [M_BITS-1:0]        div_q;
  logic [M_BITS-1:0]        remo_q;
  logic                     ovfo_q;

  logic [CNT_W-1:0]  b_log;
  logic [M_BITS-1:0] div_eff;
  logic [M_BITS-1:0] rem_shift;
  logic [M_BITS-1:0] emit_rem;
  logic              accept;
  logic              emit;

  // floor(log2(m)); a zero divisor reads as one
  always_comb begin
    b_log = '0;
    for (int i = 1; i < M_BITS; i++) begin
      if (div_i[i]) begin
        b_log = CNT_W'(i);
      end
    end
  end

  assign div_eff     = (div_i == '0) ? M_BITS'(1) : div_i;
  assign rem_shift   = M_BITS'({rem_q, code_bit_i});
  assign bit_ready_o = !code_v_q || code_ready_i;
  assign accept      = bit_valid_i && bit_ready_o;

  always_comb begin
    in_rem_d = in_rem_q;
    q_cnt_d  = q_cnt_q;
    ovf_d    = ovf_q;
    rem_d    = rem_q;
    left_d   = left_q;
    emit     = 1'b0;
    emit_rem = '0;
    if (accept) begin
      if (!in_rem_q) begin
        if (code_bit_i) begin
          // saturate the unary count, flag the clamp
          if (&q_cnt_q) begin
            ovf_d = 1'b1;
          end else begin
            q_cnt_d = q_cnt_q + 1'b1;
          end
        end else if (b_log == '0) begin
          emit = 1'b1;
        end else begin
          in_rem_d = 1'b1;
          left_d   = b_log;
          rem_d    = '0;
        end
      end else begin
        rem_d  = rem_shift;
        left_d = left_q - 1'b1;
        if (left_q == CNT_W'(1)) begin
          emit     = 1'b1;
          emit_rem = rem_shift;
        end
      end
    end
    if (emit) begin
      in_rem_d = 1'b0;
      q_cnt_d  = '0;
      ovf_d    = 1'b0;
      rem_d    = '0;
      left_d   = '0;
    end
  end

  always_comb begin
    code_v_d = code_v_q;
    if (emit) begin
      code_v_d = 1'b1;
    end else if (code_ready_i) begin
      code_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_rem_q <= 1'b0;
      q_cnt_q  <= '0;
      ovf_q    <= 1'b0;
      rem_q    <= '0;
      left_q   <= '0;
      code_v_q <= 1'b0;
    end else begin
      in_rem_q <= in_rem_d;
      q_cnt_q  <= q_cnt_d;
      ovf_q    <= ovf_d;
      rem_q    <= rem_d;
      left_q   <= left_d;
      code_v_q <= code_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      quot_q <= q_cnt_q;
      div_q  <= div_eff;
      remo_q <= emit_rem;
      ovfo_q <= ovf_q;
    end
  end

  assign code_valid_o = code_v_q;
  assign quot_o       = quot_q;
  assign div_o        = div_q;
  assign rem_o        = remo_q;
  assign ovf_o        = ovfo_q;

endmodule : gzbd_bit_parser

// ===== src/gzbd_value_unit.sv =====
// Value unit: forms q*m + r, undoes the zigzag map and clamps to 32 bits.
module gzbd_value_unit #(
  parameter int unsigned QUOTIENT_BITS = 16,
  parameter int unsigned M_BITS        = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     code_valid_i,
  output logic                     code_ready_o,
  input  logic [QUOTIENT_BITS-1:0] quot_i,
  input  logic [M_BITS-1:0]        div_i,
  input  logic [M_BITS-1:0]        rem_i,
  input  logic                     ovf_i,
  output logic                     value_valid_o,
  input  logic                     value_ready_i,
  output logic [gzbd_pkg::VALUE_W-1:0] value_o,
  output logic                     sat_o
);

  import gzbd_pkg::*;

  localparam int unsigned PW = QUOTIENT_BITS + M_BITS;
  localparam int unsigned EW = PW + VALUE_W;

  logic               prod_v_q;
  logic [PW-1:0]      prod_q;
  logic [M_BITS-1:0]  prem_q;
  logic               povf_q;

  logic               out_v_q;
  logic [VALUE_W-1:0] value_q;
  logic               sat_q;

  logic               out_ready;
  logic               prod_ready;
  logic               prod_load;
  logic               out_load;
  logic [PW-1:0]      v_sum;
  logic [EW-1:0]      v_ext;
  logic [VALUE_W-1:0] half;
  logic               clamp;
  logic [VALUE_W-1:0] value_d;

  assign out_ready    = value_ready_i || !out_v_q;
  assign prod_ready   = out_ready || !prod_v_q;
  assign code_ready_o = prod_ready;
  assign prod_load    = code_valid_i && prod_ready;
  assign out_load     = prod_v_q && out_ready;

  // odd v maps to -(v/2 + 1), which is the complement of v/2
  assign v_sum = prod_q + PW'(prem_q);
  assign v_ext = EW'(v_sum);
  assign half  = v_ext[VALUE_W:1];
  assign clamp = |(v_ext >> VALUE_W);

  always_comb begin
    if (v_sum[0]) begin
      value_d = clamp ? VALUE_NEG_MIN : ~half;
    end else begin
      value_d = clamp ? VALUE_POS_MAX : half;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (prod_ready) begin
        prod_v_q <= code_valid_i;
      end
      if (out_ready) begin
        out_v_q <= prod_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (prod_load) begin
      prod_q <= PW'(quot_i) * PW'(div_i);
      prem_q <= rem_i;
      povf_q <= ovf_i;
    end
    if (out_load) begin
      value_q <= value_d;
      sat_q   <= povf_q;
    end
  end

  assign value_valid_o = out_v_q;
  assign value_o       = value_q;
  assign sat_o         = sat_q;

endmodule : gzbd_value_unit
